// ===== rtl/core/mpwl_pkg.sv =====
package mpwl_pkg;

   localparam int MAX_ROW_PIXELS_DEF = 4096;
   localparam int MAX_BOX_HALF_DEF   = 64;

   localparam int PIX_W   = 16;
   localparam int CHAN_W  = 8;
   localparam int RL_W    = 13;
   localparam int BOX_W   = 8;
   localparam int IDX_W   = 3;
   localparam int CSR_W   = 16;
   localparam int NUM_W   = PIX_W + CHAN_W;
   localparam int QCNT_W  = 3;

   localparam logic [PIX_W-1:0]  PIX_SAT   = 16'hFFFF;
   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

   typedef enum logic [IDX_W-1:0] {
      CSR_ROW_LENGTH  = 3'd0,
      CSR_FRAME_ROWS  = 3'd1,
      CSR_BOX_WIDTH   = 3'd2,
      CSR_BOX_HEIGHT  = 3'd3,
      CSR_WINDOW_LOW  = 3'd4,
      CSR_WINDOW_HIGH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic merge;
      logic win;
      logic div_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic col_end;
      logic emit;
      logic need_div;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/mpwl_ctrl.sv =====
module mpwl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  mpwl_pkg::stat_type stat,
   output mpwl_pkg::cmd_type  cmd
);
   import mpwl_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MERGE = 5'b00010,
      ST_WIN   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (stat.col_end) state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = stat.emit ? ST_WIN : ST_IDLE;
         end
         ST_WIN: begin
            cmd.win  = 1'b1;
            state_in = stat.need_div ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_short_pixel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && !stat.col_end) |=> state_ff == ST_IDLE)
      else $error("pixel without box end left idle");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && stat.div_last) |=> state_ff == ST_FIN)
      else $error("divider finish not followed by output");
   a_no_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && !stat.emit) |=> state_ff == ST_IDLE)
      else $error("merge without result did not return");
endmodule

// ===== rtl/core/mpwl_datapath.sv =====
module mpwl_datapath #(
   parameter int MAX_ROW_PIXELS = mpwl_pkg::MAX_ROW_PIXELS_DEF,
   parameter int MAX_BOX_HALF   = mpwl_pkg::MAX_BOX_HALF_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mpwl_pkg::PIX_W-1:0]     req_tdata,
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [3*mpwl_pkg::CHAN_W-1:0]  rsp_tdata,
   output logic                           rsp_tuser,
   input  logic                           csr_we,
   input  logic [mpwl_pkg::IDX_W-1:0]     csr_index,
   input  logic [mpwl_pkg::CSR_W-1:0]     csr_wdata,
   input  mpwl_pkg::cmd_type              cmd,
   output mpwl_pkg::stat_type             stat
);
   import mpwl_pkg::*;

   localparam int CW   = $clog2(MAX_ROW_PIXELS);
   localparam int LW   = CW + 1;
   localparam int BOXM = 2 * MAX_BOX_HALF;
   localparam int IBW  = $clog2(BOXM);
   localparam int BLW  = IBW + 1;

   logic [RL_W-1:0]  row_length_ff, frame_rows_ff;
   logic [BOX_W-1:0] box_width_ff, box_height_ff;
   logic [PIX_W-1:0] window_low_ff, window_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= 13'd1024;
         frame_rows_ff  <= 13'd1024;
         box_width_ff   <= 8'd1;
         box_height_ff  <= 8'd1;
         window_low_ff  <= '0;
         window_high_ff <= PIX_SAT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_LENGTH:  row_length_ff  <= csr_wdata[RL_W-1:0];
            CSR_FRAME_ROWS:  frame_rows_ff  <= csr_wdata[RL_W-1:0];
            CSR_BOX_WIDTH:   box_width_ff   <= csr_wdata[BOX_W-1:0];
            CSR_BOX_HEIGHT:  box_height_ff  <= csr_wdata[BOX_W-1:0];
            CSR_WINDOW_LOW:  window_low_ff  <= csr_wdata;
            CSR_WINDOW_HIGH: window_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [LW-1:0]  rl, fr;
   logic [BLW-1:0] bw, bh;

   always_comb begin
      if (row_length_ff == '0)                    rl = LW'(1);
      else if (32'(row_length_ff) > MAX_ROW_PIXELS) rl = LW'(MAX_ROW_PIXELS);
      else                                        rl = LW'(row_length_ff);
      if (frame_rows_ff == '0)                    fr = LW'(1);
      else if (32'(frame_rows_ff) > MAX_ROW_PIXELS) fr = LW'(MAX_ROW_PIXELS);
      else                                        fr = LW'(frame_rows_ff);
      if (box_width_ff == '0)                     bw = BLW'(1);
      else if (32'(box_width_ff) > BOXM)          bw = BLW'(BOXM);
      else                                        bw = BLW'(box_width_ff);
      if (box_height_ff == '0)                    bh = BLW'(1);
      else if (32'(box_height_ff) > BOXM)         bh = BLW'(BOXM);
      else                                        bh = BLW'(box_height_ff);
   end

   logic [CW-1:0]    col_count_ff, row_count_ff, box_index_ff;
   logic [IBW-1:0]   col_in_box_ff, row_in_box_ff;
   logic [PIX_W-1:0] running_max_ff;

   logic [CW-1:0]    cc, rc, bi, slot;
   logic [IBW-1:0]   cib, rib;
   logic [PIX_W-1:0] rm, rm_new;
   logic             last_col, last_row, col_end, row_end_box;

   always_comb begin
      if (req_tuser) begin
         cc = '0; rc = '0; bi = '0; cib = '0; rib = '0; rm = '0;
      end else begin
         cc  = col_count_ff;
         rc  = row_count_ff;
         bi  = box_index_ff;
         cib = col_in_box_ff;
         rib = row_in_box_ff;
         rm  = running_max_ff;
      end
      last_col    = ({1'b0, cc} + LW'(1)) >= rl;
      last_row    = ({1'b0, rc} + LW'(1)) >= fr;
      col_end     = last_col || (({1'b0, cib} + BLW'(1)) >= bw);
      row_end_box = last_row || (({1'b0, rib} + BLW'(1)) >= bh);
      rm_new      = (cib == '0 || req_tdata > rm) ? req_tdata : rm;
      slot        = (32'(bi) < MAX_ROW_PIXELS) ? bi : CW'(MAX_ROW_PIXELS - 1);
   end

   logic [PIX_W-1:0] rm_hold_ff, mem_q_ff, m_ff, m_merge;
   logic [CW-1:0]    slot_ff;
   logic             rib_nz_ff, emit_ff, row_end_ff, col_end_ff;
   logic [PIX_W-1:0] column_max_store [MAX_ROW_PIXELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         box_index_ff   <= '0;
         col_in_box_ff  <= '0;
         row_in_box_ff  <= '0;
         running_max_ff <= '0;
         col_end_ff     <= 1'b0;
         emit_ff        <= 1'b0;
      end else if (cmd.accept) begin
         col_end_ff <= col_end;
         emit_ff    <= col_end && row_end_box;
         if (last_col) begin
            col_count_ff   <= '0;
            box_index_ff   <= '0;
            col_in_box_ff  <= '0;
            running_max_ff <= '0;
            if (last_row) begin
               row_count_ff  <= '0;
               row_in_box_ff <= '0;
            end else begin
               row_count_ff  <= rc + CW'(1);
               row_in_box_ff <= row_end_box ? '0 : rib + IBW'(1);
            end
         end else begin
            col_count_ff  <= cc + CW'(1);
            row_count_ff  <= rc;
            row_in_box_ff <= rib;
            if (col_end) begin
               box_index_ff   <= bi + CW'(1);
               col_in_box_ff  <= '0;
               running_max_ff <= '0;
            end else begin
               box_index_ff   <= bi;
               col_in_box_ff  <= cib + IBW'(1);
               running_max_ff <= rm_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rm_hold_ff <= rm_new;
         slot_ff    <= slot;
         rib_nz_ff  <= (rib != '0);
         row_end_ff <= last_col;
         mem_q_ff   <= column_max_store[slot];
      end
      if (cmd.merge) begin
         column_max_store[slot_ff] <= m_merge;
         m_ff                      <= m_merge;
      end
   end

   assign m_merge = (rib_nz_ff && mem_q_ff > rm_hold_ff) ? mem_q_ff : rm_hold_ff;

   logic [PIX_W-1:0]  span, lift;
   logic [NUM_W-1:0]  num_ff, dsh_ff;
   logic [CHAN_W-1:0] q_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              below, above;

   assign below = m_ff <= window_low_ff;
   assign above = m_ff >= window_high_ff;
   assign span  = window_high_ff - window_low_ff;
   assign lift  = m_ff - window_low_ff;

   always_ff @(posedge clock) begin
      if (cmd.win) begin
         num_ff <= {lift, 8'd0} - NUM_W'(lift);
         dsh_ff <= NUM_W'(span) << 7;
         cnt_ff <= '1;
         q_ff   <= below ? '0 : (above ? CHAN_FULL : '0);
      end else if (cmd.div_step) begin
         if (num_ff >= dsh_ff) begin
            num_ff <= num_ff - dsh_ff;
            q_ff   <= {q_ff[CHAN_W-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[CHAN_W-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - QCNT_W'(1);
      end
   end

   logic rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset)           rsp_tvalid_ff <= 1'b0;
      else if (cmd.load)   rsp_tvalid_ff <= 1'b1;
      else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_tuser <= row_end_ff;
         if (m_ff == PIX_SAT) rsp_tdata <= {8'd0, 8'd0, CHAN_FULL};
         else                 rsp_tdata <= {~q_ff, ~q_ff, ~q_ff};
      end
   end

   assign rsp_tvalid    = rsp_tvalid_ff;
   assign stat.col_end  = col_end;
   assign stat.emit     = emit_ff && col_end_ff;
   assign stat.need_div = !below && !above;
   assign stat.div_last = (cnt_ff == '0);
   assign stat.out_free = !rsp_tvalid_ff || rsp_tready;

   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:8] == rsp_tdata[23:16]))
      else $error("green and blue differ");
   a_red_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[7:0] != rsp_tdata[15:8])
         |-> (rsp_tdata[7:0] == CHAN_FULL && rsp_tdata[15:8] == 8'd0))
      else $error("bad saturation color");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result overwritten before transfer");
endmodule

// ===== rtl/core/max_pool_window_level_pixel_map.sv =====
// Max-pool downsampler with window/level mapping. Pixels enter in raster
// order (tdata = pixel, tuser = frame_start) and are tiled into
// box_width x box_height boxes, clipped at the frame edges. When the last
// pixel of a box arrives, the box maximum is windowed to 0..255 and sent
// as inverted gray on red/green/blue, or pure red for a saturated box;
// tuser marks the last box of an output row. A pixel that ends no box
// column updates the running maximum; one that ends a box column adds a
// column store read and merge, and one that emits a result adds the
// window stage, the 8-step serial divider for a level inside the window
// and any wait for the prior result to be taken; no new pixel is taken
// meanwhile. The column store is not cleared after reset.
module max_pool_window_level_pixel_map #(
   parameter int MAX_ROW_PIXELS = mpwl_pkg::MAX_ROW_PIXELS_DEF,
   parameter int MAX_BOX_HALF   = mpwl_pkg::MAX_BOX_HALF_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mpwl_pkg::PIX_W-1:0]    req_tdata,  // pixel
   input  logic                          req_tuser,  // frame_start
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [3*mpwl_pkg::CHAN_W-1:0] rsp_tdata,  // red, green, blue
   output logic                          rsp_tuser,  // row_end
   input  logic                          csr_we,
   input  logic [mpwl_pkg::IDX_W-1:0]    csr_index,
   input  logic [mpwl_pkg::CSR_W-1:0]    csr_wdata
);
   import mpwl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mpwl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mpwl_datapath #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
      .MAX_BOX_HALF   (MAX_BOX_HALF)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );
endmodule

// ===== test/tb_max_pool_window_level_pixel_map.sv =====
module tb_max_pool_window_level_pixel_map;
   timeunit 1ns;
   timeprecision 1ps;
   import mpwl_pkg::*;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              row_end;
   } box_color_type;

   typedef struct {
      bit                is_csr;
      csr_index_type     index;
      logic [CSR_W-1:0]  value;
      logic [PIX_W-1:0]  pixel;
      bit                frame_start;
      bit                typed;
      box_color_type     color;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [PIX_W-1:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [3*CHAN_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   max_pool_window_level_pixel_map uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // shadow registers and pooling state
   logic [12:0] row_len_q, frame_rows_q;
   logic [7:0]  box_w_q, box_h_q;
   logic [15:0] win_lo_q, win_hi_q;
   logic [15:0] col_max_mem [MAX_ROW_PIXELS_DEF];
   int unsigned run_max, col_cnt, row_cnt, col_in_box, row_in_box, box_col;

   box_color_type box_colors_due[$];
   int errors = 0, pixels_sent = 0, colors_seen = 0, phases = 0;
   bit no_gaps = 0, hold_rsp = 0;

   function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return v > hi ? hi : v;
   endfunction

   function automatic int unsigned window_level(int unsigned d);
      if (d <= win_lo_q) return 0;
      if (d >= win_hi_q) return 255;
      return ((d - win_lo_q) * 255) / (win_hi_q - win_lo_q);
   endfunction

   function automatic bit pool_pixel(input logic [PIX_W-1:0] pix, input bit fs,
                                     output box_color_type c);
      int unsigned rl, fr, bw, bh, m, slot, g;
      bit lc, lr, bce, bre, got;
      rl = clamp_reg(row_len_q, MAX_ROW_PIXELS_DEF);
      fr = clamp_reg(frame_rows_q, MAX_ROW_PIXELS_DEF);
      bw = clamp_reg(box_w_q, 2 * MAX_BOX_HALF_DEF);
      bh = clamp_reg(box_h_q, 2 * MAX_BOX_HALF_DEF);
      got = 0;
      c = '{default: '0};
      if (fs) begin
         run_max = 0; col_cnt = 0; row_cnt = 0;
         col_in_box = 0; row_in_box = 0; box_col = 0;
      end
      lc = col_cnt + 1 >= rl;
      lr = row_cnt + 1 >= fr;
      bce = lc || (col_in_box + 1 >= bw);
      bre = lr || (row_in_box + 1 >= bh);
      if (col_in_box == 0 || pix > run_max) run_max = pix;
      if (bce) begin
         slot = box_col < MAX_ROW_PIXELS_DEF ? box_col : MAX_ROW_PIXELS_DEF - 1;
         m = run_max;
         if (row_in_box != 0 && col_max_mem[slot] > m) m = col_max_mem[slot];
         col_max_mem[slot] = 16'(m);
         if (bre) begin
            g = 255 - window_level(m);
            if (m == PIX_SAT) c = '{CHAN_FULL, 8'd0, 8'd0, lc};
            else c = '{8'(g), 8'(g), 8'(g), lc};
            got = 1;
         end
         box_col = (box_col + 1) & 12'hFFF;
         col_in_box = 0;
         run_max = 0;
      end else begin
         col_in_box = (col_in_box + 1) & 7'h7F;
      end
      if (lc) begin
         col_cnt = 0; box_col = 0; col_in_box = 0; run_max = 0;
         if (lr) begin
            row_cnt = 0; row_in_box = 0;
         end else begin
            row_cnt = (row_cnt + 1) & 12'hFFF;
            row_in_box = bre ? 0 : ((row_in_box + 1) & 7'h7F);
         end
      end else begin
         col_cnt = (col_cnt + 1) & 12'hFFF;
      end
      return got;
   endfunction

   // hold until the block is drained, then allow for a column store access in flight
   task automatic wait_drained();
      req_tvalid <= 0;
      while (box_colors_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_ROW_LENGTH:  row_len_q = v[12:0];
         CSR_FRAME_ROWS:  frame_rows_q = v[12:0];
         CSR_BOX_WIDTH:   box_w_q = v[7:0];
         CSR_BOX_HEIGHT:  box_h_q = v[7:0];
         CSR_WINDOW_LOW:  win_lo_q = v;
         CSR_WINDOW_HIGH: win_hi_q = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [PIX_W-1:0] pix, bit fs, bit typed, box_color_type tc);
      int gap;
      box_color_type c;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      if (pool_pixel(pix, fs, c) || typed) box_colors_due.push_back(typed ? tc : c);
      req_tvalid <= 1;
      req_tdata <= pix;
      req_tuser <= fs;
      pixels_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   always begin
      int n;
      if (hold_rsp) begin
         rsp_tready <= 0;
         repeat (300) @(posedge clock);
         hold_rsp = 0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
         rsp_tready <= 0;
         repeat (n) @(posedge clock);
      end
      rsp_tready <= 1;
      do @(posedge clock); while (!rsp_tvalid);
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      box_color_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            colors_seen++;
            if (box_colors_due.size() == 0) begin
               $error("unexpected transfer red=%0d green=%0d blue=%0d",
                      rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]);
               errors++;
            end else begin
               e = box_colors_due.pop_front();
               if (rsp_tdata[7:0] !== e.red) begin
                  $error("red exp %0d got %0d", e.red, rsp_tdata[7:0]); errors++;
               end
               if (rsp_tdata[15:8] !== e.green) begin
                  $error("green exp %0d got %0d", e.green, rsp_tdata[15:8]); errors++;
               end
               if (rsp_tdata[23:16] !== e.blue) begin
                  $error("blue exp %0d got %0d", e.blue, rsp_tdata[23:16]); errors++;
               end
               if (rsp_tuser !== e.row_end) begin
                  $error("row_end exp %0d got %0d", e.row_end, rsp_tuser); errors++;
               end
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 3000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic stim_row_type pix_row(logic [PIX_W-1:0] p, bit fs);
      return '{0, CSR_ROW_LENGTH, '0, p, fs, 0, '{default: '0}};
   endfunction

   function automatic stim_row_type typed_row(logic [PIX_W-1:0] p, bit fs, box_color_type c);
      return '{0, CSR_ROW_LENGTH, '0, p, fs, 1, c};
   endfunction

   function automatic stim_row_type reg_row(csr_index_type i, logic [CSR_W-1:0] v);
      return '{1, i, v, '0, 0, 0, '{default: '0}};
   endfunction

   stim_row_type directed[$];

   initial begin
      int unsigned rl, fr, count, extra;
      bit in_csr;
      logic [PIX_W-1:0] p;
      row_len_q = 1024; frame_rows_q = 1024; box_w_q = 1; box_h_q = 1;
      win_lo_q = 0; win_hi_q = 16'hFFFF;
      run_max = 0; col_cnt = 0; row_cnt = 0; col_in_box = 0; row_in_box = 0; box_col = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      directed = '{
         typed_row(16'd0, 1, '{8'd255, 8'd255, 8'd255, 1'b0}),
         typed_row(16'hFFFF, 0, '{8'd255, 8'd0, 8'd0, 1'b0}),
         typed_row(16'd1, 0, '{8'd255, 8'd255, 8'd255, 1'b0}),
         typed_row(16'hFFFE, 0, '{8'd1, 8'd1, 8'd1, 1'b0}),
         pix_row(16'd32768, 0),
         reg_row(CSR_ROW_LENGTH, 16'd3), reg_row(CSR_FRAME_ROWS, 16'd2),
         reg_row(CSR_BOX_WIDTH, 16'd2), reg_row(CSR_BOX_HEIGHT, 16'd2),
         pix_row(16'd100, 1), pix_row(16'd7, 0), pix_row(16'hFFFF, 0),
         pix_row(16'd3, 0), pix_row(16'hFFFF, 0), pix_row(16'd9, 0),
         reg_row(CSR_ROW_LENGTH, 16'd0), reg_row(CSR_FRAME_ROWS, 16'd0),
         reg_row(CSR_WINDOW_LOW, 16'd100), reg_row(CSR_WINDOW_HIGH, 16'd50),
         typed_row(16'd100, 1, '{8'd255, 8'd255, 8'd255, 1'b1}),
         typed_row(16'd101, 0, '{8'd0, 8'd0, 8'd0, 1'b1}),
         typed_row(16'hFFFF, 0, '{8'd255, 8'd0, 8'd0, 1'b1})
      };
      in_csr = 0;
      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            if (!in_csr) wait_drained();
            write_reg(directed[i].index, directed[i].value);
            in_csr = 1;
         end else begin
            if (in_csr) csr_we <= 0;
            in_csr = 0;
            send_pixel(directed[i].pixel, directed[i].frame_start,
                       directed[i].typed, directed[i].color);
         end
      end

      while (pixels_sent < 720) begin
         wait_drained();
         phases++;
         case ($urandom_range(0, 9))
            0: rl = 0;
            1: rl = 13'h1FFF;
            2: rl = 4096;
            default: rl = $urandom_range(1, 12);
         endcase
         fr = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 0 : 13'h1FFF)
                                         : $urandom_range(1, 6);
         write_reg(CSR_ROW_LENGTH, CSR_W'(rl));
         write_reg(CSR_FRAME_ROWS, CSR_W'(fr));
         case ($urandom_range(0, 7))
            0: write_reg(CSR_BOX_WIDTH, '0);
            1: write_reg(CSR_BOX_WIDTH, $urandom_range(0, 1) ? 16'd128 : 16'd255);
            default: write_reg(CSR_BOX_WIDTH, CSR_W'($urandom_range(1, 5)));
         endcase
         case ($urandom_range(0, 7))
            0: write_reg(CSR_BOX_HEIGHT, '0);
            1: write_reg(CSR_BOX_HEIGHT, $urandom_range(0, 1) ? 16'd128 : 16'd255);
            default: write_reg(CSR_BOX_HEIGHT, CSR_W'($urandom_range(1, 4)));
         endcase
         case ($urandom_range(0, 4))
            0: begin write_reg(CSR_WINDOW_LOW, '0); write_reg(CSR_WINDOW_HIGH, 16'hFFFF); end
            1: begin write_reg(CSR_WINDOW_LOW, 16'hFFFF); write_reg(CSR_WINDOW_HIGH, '0); end
            default: begin
               write_reg(CSR_WINDOW_LOW, CSR_W'($urandom_range(0, 40000)));
               write_reg(CSR_WINDOW_HIGH, CSR_W'($urandom_range(0, 65535)));
            end
         endcase
         csr_we <= 0;
         no_gaps = (phases % 4 == 0);
         if (phases == 3) hold_rsp = 1;
         count = clamp_reg(rl, 4096) * clamp_reg(fr, 4096);
         if (count > 60) count = $urandom_range(20, 60);
         extra = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
         for (int k = 0; k < count + extra; k++) begin
            case ($urandom_range(0, 7))
               0: p = '0;
               1: p = PIX_SAT;
               2: p = PIX_W'(win_lo_q + $urandom_range(0, 3));
               3: p = PIX_W'(win_hi_q - $urandom_range(0, 3));
               default: p = PIX_W'($urandom);
            endcase
            send_pixel(p, k == 0 || $urandom_range(0, 40) == 0, 0, '{default: '0});
         end
      end

      req_tvalid <= 0;
      while (box_colors_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("covered %0d pixels, %0d box colors, %0d register settings",
               pixels_sent, colors_seen, phases + 3);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

// ===== max_pool_window_level_pixel_map.f =====
rtl/core/mpwl_pkg.sv
rtl/core/mpwl_ctrl.sv
rtl/core/mpwl_datapath.sv
rtl/core/max_pool_window_level_pixel_map.sv
test/tb_max_pool_window_level_pixel_map.sv
